// ===== src/pcm_pkg.sv =====
// Shared types and constants for the pseudocolor map.
package pcm_pkg;

    localparam int LEVEL_W = 8;
    localparam int CHAN_W  = 8;
    localparam int CMAP_W  = 3;

    typedef enum logic [CMAP_W-1:0] {
        CMAP_GRAY   = 3'd0,
        CMAP_COOL   = 3'd1,
        CMAP_HOT    = 3'd2,
        CMAP_JET    = 3'd3,
        CMAP_COPPER = 3'd4,
        CMAP_SUMMER = 3'd5,
        CMAP_AUTUMN = 3'd6,
        CMAP_WINTER = 3'd7
    } t_colormap;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } t_rgb;

endpackage

// ===== src/pcm_if.sv =====
// Valid/ready channel interfaces: gray level in, RGB beat out.
interface pcm_in_if import pcm_pkg::*;;
    logic               valid;
    logic               ready;
    logic [LEVEL_W-1:0] level;

    modport source (output valid, output level, input ready);
    modport sink   (input valid, input level, output ready);
endinterface

interface pcm_out_if import pcm_pkg::*;;
    logic              valid;
    logic              ready;
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;

    modport source (output valid, output red, output green, output blue, input ready);
    modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

// ===== src/pcm_ratio.sv =====
// Constant affine ratio: floor((A*x+B)/D) clamped to 0..LEVELS-1.
module pcm_ratio import pcm_pkg::*; #(
    parameter int     LEVELS = 256,
    parameter longint A      = 1,
    parameter longint B      = 0,
    parameter longint D      = 1
) (
    input  logic [LEVEL_W-1:0]         i_x,
    output logic [$clog2(LEVELS)-1:0]  o_y
);

    localparam int     VW   = $clog2(LEVELS);
    localparam int     EW   = 64;
    localparam longint TOP  = longint'(LEVELS) - 1;
    localparam longint XM   = (longint'(1) << LEVEL_W) - 1;
    localparam longint AA   = (A < 0) ? -A : A;
    localparam longint BA   = (B < 0) ? -B : B;
    localparam longint TMAX = AA * XM + BA;
    // 2^SH >= TMAX*D makes the reciprocal product exact for all t in 0..TMAX
    localparam int     SH   = $clog2(TMAX + 1) + $clog2(D);
    localparam longint M    = ((longint'(1) << SH) + D - 1) / D;
    localparam longint PMAX = TMAX * M;
    localparam int     PW   = $clog2(PMAX + 1) + 1;

    localparam logic signed [PW-1:0] AM_C = PW'(A * M);
    localparam logic signed [PW-1:0] BM_C = PW'(B * M);

    logic signed [PW-1:0] xs;
    logic signed [PW-1:0] p;
    logic [EW-1:0]        q;

    assign xs = PW'(i_x);
    assign p  = xs * AM_C + BM_C;
    assign q  = EW'(p[PW-2:SH]);

    always_comb begin
        if (p[PW-1]) begin
            o_y = '0;
        end else if (q > EW'(TOP)) begin
            o_y = VW'(TOP);
        end else begin
            o_y = q[VW-1:0];
        end
    end

endmodule

// ===== src/pcm_chan.sv =====
// Colormap datapath: clamps the level and evaluates all eight maps.
module pcm_chan import pcm_pkg::*; #(
    parameter int LEVELS = 256
) (
    input  logic [LEVEL_W-1:0] i_level,
    input  t_colormap          i_cmap,
    output t_rgb               o_rgb
);

    localparam int VW       = $clog2(LEVELS);
    localparam int WW       = VW + 5;
    localparam int TOP      = LEVELS - 1;
    localparam int XFULL    = (1 << LEVEL_W) - 1;
    localparam int XMAX     = (TOP > XFULL) ? XFULL : TOP;
    localparam int H        = (3 * LEVELS + 4) / 8;
    localparam int HD       = TOP - 2 * H;
    localparam int Q        = (LEVELS + 2) / 4;
    localparam int SUMMER_B = (4 * TOP + 5) / 10;

    logic [LEVEL_W-1:0] x;
    logic [WW-1:0]      xw;
    logic [WW-1:0]      x2;
    logic [WW-1:0]      cop_r_w;
    logic [WW-1:0]      sum_g_w;
    logic [WW-1:0]      win_b_w;
    logic [VW-1:0]      cop_r, cop_g, cop_b;
    logic [VW-1:0]      hot_r_lin, hot_g_lin, hot_b_lin;
    logic [VW-1:0]      hot_r, hot_g, hot_b;
    logic [2:0][VW-1:0] jet;
    logic [VW-1:0]      vr, vg, vb;

    assign x  = (i_level > LEVEL_W'(XMAX)) ? LEVEL_W'(XMAX) : i_level;
    assign xw = WW'(x);
    assign x2 = WW'({x, 1'b0});

    // copper
    assign cop_r_w = (xw * WW'(10) + WW'(4)) >> 3;
    assign cop_r   = (cop_r_w > WW'(TOP)) ? VW'(TOP) : cop_r_w[VW-1:0];

    pcm_ratio #(.LEVELS(LEVELS), .A(15624), .B(10000), .D(20000)) u_cop_g (
        .i_x(x), .o_y(cop_g)
    );
    pcm_ratio #(.LEVELS(LEVELS), .A(9950), .B(10000), .D(20000)) u_cop_b (
        .i_x(x), .o_y(cop_b)
    );

    // summer green and winter blue are halves
    assign sum_g_w = (WW'(TOP) + xw + WW'(1)) >> 1;
    assign win_b_w = (WW'(2 * TOP) - xw + WW'(1)) >> 1;

    // hot
    pcm_ratio #(
        .LEVELS(LEVELS), .A(longint'(2 * TOP)), .B(longint'(H)), .D(longint'(2 * H))
    ) u_hot_r (
        .i_x(x), .o_y(hot_r_lin)
    );
    pcm_ratio #(
        .LEVELS(LEVELS), .A(longint'(2 * TOP)),
        .B(longint'(H) - longint'(2 * H) * TOP), .D(longint'(2 * H))
    ) u_hot_g (
        .i_x(x), .o_y(hot_g_lin)
    );
    pcm_ratio #(
        .LEVELS(LEVELS), .A(longint'(2 * TOP)),
        .B(longint'(HD) - longint'(4 * H) * TOP), .D(longint'(2 * HD))
    ) u_hot_b (
        .i_x(x), .o_y(hot_b_lin)
    );

    assign hot_r = (xw <= WW'(H)) ? hot_r_lin : VW'(TOP);
    assign hot_g = (xw <= WW'(H))     ? '0 :
                   (xw <= WW'(2 * H)) ? hot_g_lin : VW'(TOP);
    assign hot_b = (xw <= WW'(2 * H)) ? '0 : hot_b_lin;

    // jet: trapezoids shifted by 1.5Q, 0.5Q and -0.5Q
    for (genvar k = 0; k < 3; k++) begin : g_jet
        localparam int C = (k == 0) ? 3 * Q : ((k == 1) ? Q : -Q);
        logic [VW-1:0] rise;
        logic [VW-1:0] fall;

        pcm_ratio #(
            .LEVELS(LEVELS), .A(longint'(4 * TOP)),
            .B(longint'(2 * Q) - longint'(2 * C) * TOP), .D(longint'(4 * Q))
        ) u_rise (
            .i_x(x), .o_y(rise)
        );
        pcm_ratio #(
            .LEVELS(LEVELS), .A(-longint'(4 * TOP)),
            .B(longint'(2 * Q) + longint'(12 * Q + 2 * C) * TOP), .D(longint'(4 * Q))
        ) u_fall (
            .i_x(x), .o_y(fall)
        );

        assign jet[k] = (x2 <= WW'(2 * Q + C)) ? rise :
                        (x2 <= WW'(4 * Q + C)) ? VW'(TOP) :
                        (x2 <= WW'(6 * Q + C)) ? fall : '0;
    end

    always_comb begin
        case (i_cmap)
            CMAP_GRAY: begin
                vr = VW'(x);
                vg = VW'(x);
                vb = VW'(x);
            end
            CMAP_COOL: begin
                vr = VW'(x);
                vg = VW'(TOP) - VW'(x);
                vb = VW'(TOP);
            end
            CMAP_HOT: begin
                vr = hot_r;
                vg = hot_g;
                vb = hot_b;
            end
            CMAP_JET: begin
                vr = jet[0];
                vg = jet[1];
                vb = jet[2];
            end
            CMAP_COPPER: begin
                vr = cop_r;
                vg = cop_g;
                vb = cop_b;
            end
            CMAP_SUMMER: begin
                vr = VW'(x);
                vg = sum_g_w[VW-1:0];
                vb = VW'(SUMMER_B);
            end
            CMAP_AUTUMN: begin
                vr = VW'(TOP);
                vg = VW'(x);
                vb = '0;
            end
            CMAP_WINTER: begin
                vr = '0;
                vg = VW'(x);
                vb = win_b_w[VW-1:0];
            end
            default: begin
                vr = '0;
                vg = '0;
                vb = '0;
            end
        endcase
    end

    assign o_rgb.red   = CHAN_W'(vr);
    assign o_rgb.green = CHAN_W'(vg);
    assign o_rgb.blue  = CHAN_W'(vb);

endmodule

// ===== src/pseudocolor_map.sv =====
// Pseudocolor map top level: level register, colormap datapath, RGB result register.
// An accepted level beat is held in the level register, then in the result register that drives o_out.
// Throughput: 1 beat per cycle while o_out is ready; set by the single pass through the colormap datapath.
// Backpressure: while an RGB beat waits on o_out, one more level is taken; then input stalls.
// Reset (synchronous, active low): both stages empty, colormap returns to gray.
module pseudocolor_map import pcm_pkg::*; #(
    parameter int LEVELS = 256
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [CMAP_W-1:0] i_cfg_wdata,
    pcm_in_if.sink            i_in,
    pcm_out_if.source         o_out
);

    t_colormap          r_cmap;
    logic               r_s1_valid;
    logic [LEVEL_W-1:0] r_s1_level;
    logic               r_out_valid;
    t_rgb               r_out_rgb;
    t_rgb               n_out_rgb;
    logic               out_free;
    logic               s1_free;

    assign out_free   = !r_out_valid || o_out.ready;
    assign s1_free    = !r_s1_valid || out_free;
    assign i_in.ready = s1_free;

    pcm_chan #(.LEVELS(LEVELS)) u_chan (
        .i_level(r_s1_level),
        .i_cmap (r_cmap),
        .o_rgb  (n_out_rgb)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmap      <= CMAP_GRAY;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cmap <= t_colormap'(i_cfg_wdata);
            end
            if (s1_free) begin
                r_s1_valid <= i_in.valid;
            end
            if (out_free) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && s1_free) begin
            r_s1_level <= i_in.level;
        end
        if (r_s1_valid && out_free) begin
            r_out_rgb <= n_out_rgb;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.red   = r_out_rgb.red;
    assign o_out.green = r_out_rgb.green;
    assign o_out.blue  = r_out_rgb.blue;

    a_in_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> r_s1_valid)
        else $error("accepted level beat not held in stage 1");

    a_s1_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && out_free) |=> r_out_valid)
        else $error("stage 1 beat lost on way to result register");

    a_cfg_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> (r_cmap == t_colormap'($past(i_cfg_wdata))))
        else $error("colormap register not updated");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (!r_s1_valid && !r_out_valid && r_cmap == CMAP_GRAY))
        else $error("pipeline not empty after reset");

endmodule
